### hdl/bsf_pkg.sv
// Shared constants for the binomial smoothing FIR.
// No dependencies; compiled first.
`default_nettype none

package bsf_pkg;

    localparam int ORDER_W     = 5;
    localparam int RESET_ORDER = 4;

endpackage

`default_nettype wire

### hdl/bsf_if.sv
// Valid/ready channels of the binomial smoothing FIR: samples, results, order writes.
// Depends on bsf_pkg.
`default_nettype none

interface bsf_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bsf_smoothed_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink   (input valid, input smoothed, output ready);
endinterface

interface bsf_cfg_if;
    import bsf_pkg::*;

    logic               valid;
    logic               ready;
    logic [ORDER_W-1:0] order;

    modport source (output valid, output order, input ready);
    modport sink   (input valid, input order, output ready);
endinterface

`default_nettype wire

### hdl/bsf_div.sv
// Restoring divider, one quotient bit per cycle, for warm-up normalisation.
// Standalone; used by binomial_smoothing_fir.
`default_nettype none

module bsf_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 31,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int CW = $clog2(QUO_W + 1);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    assign ge = (rem_reg >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(QUO_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dvs_reg <= NUM_W'(den) << (QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

### hdl/binomial_smoothing_fir.sv
// Binomial smoothing FIR: top level with sample ring, weight memory and MAC sequencer.
// Depends on bsf_pkg, bsf_if (channel interfaces) and bsf_div.
//
// Usage:
//   samples carries one signed sample per item; results returns one smoothed
//   sample per item; cfg sets the Pascal row (order); taps = min(order+1, MAX_TAPS).
//   The sample ring and the weight row live in two single-port-read memories.
//   Per item: write the sample, then one tap per cycle through memory read,
//   multiply and accumulate, then the pipeline drains. Warm-up (fewer than
//   taps samples held): the result also passes the bit-serial divider.
//   One item at a time: the next item is accepted once the result has moved
//   to the output register, which holds it until the receiver takes it.
//   A stalled receiver holds back only the item after next.
//   After reset or an order write the weight row is rebuilt in the weight
//   memory from Pascal's rule; no item is accepted meanwhile and warm-up
//   restarts. Reset loads order 4.
`default_nettype none

module binomial_smoothing_fir #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    bsf_cfg_if.sink        cfg,
    bsf_sample_if.sink     samples,
    bsf_smoothed_if.source results
);

    import bsf_pkg::*;

    localparam int RING_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int WEIGHT_W = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int ACC_W    = WEIGHT_W + SAMPLE_BITS + 1;
    localparam int OT_W     = ORDER_W + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum logic [7:0] {
        S_BUILD_INIT = 8'b0000_0001,
        S_BUILD_RD   = 8'b0000_0010,
        S_BUILD_WR   = 8'b0000_0100,
        S_IDLE       = 8'b0000_1000,
        S_MAC        = 8'b0001_0000,
        S_DRAIN      = 8'b0010_0000,
        S_DIV        = 8'b0100_0000,
        S_FIN        = 8'b1000_0000
    } state_t;

    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
    logic [WEIGHT_W-1:0]           wgt_mem  [MAX_TAPS];

    state_t             state_reg, state_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               warm_reg, warm_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RING_AW-1:0] rp_reg, rp_next;
    logic [RING_AW-1:0] k_reg, k_next;
    logic [RING_AW-1:0] br_reg, br_next;
    logic [RING_AW-1:0] bk_reg, bk_next;
    logic               rd_vld_reg;
    logic               prod_vld_reg;
    logic               out_vld_reg;

    logic [WEIGHT_W-1:0]           hold_reg, hold_next;
    logic signed [SAMPLE_BITS-1:0] ring_rd_reg;
    logic [WEIGHT_W-1:0]           wgt_rd_reg;
    logic signed [ACC_W-1:0]       prod_reg;
    logic [WEIGHT_W-1:0]           wq_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [WEIGHT_W-1:0]           wsum_reg;
    logic signed [ACC_W-1:0]       res_reg;
    logic                          sign_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg;

    logic [OT_W-1:0]          order_p1;
    logic [CNT_W-1:0]         taps_w;
    logic [CNT_W-1:0]         n_w;
    logic [CNT_W-1:0]         fill_new;
    logic [RING_AW-1:0]       wp_new;
    logic [RING_AW-1:0]       rp_inc;
    logic                     in_acc;
    logic                     cfg_acc;
    logic                     drain_done;
    logic                     ring_we;
    logic                     wgt_we;
    logic [RING_AW-1:0]       wgt_waddr;
    logic [WEIGHT_W-1:0]      wgt_wdata;
    logic [RING_AW-1:0]       wgt_raddr;
    logic                     out_load;
    logic                     div_start;
    logic                     div_done;
    logic [SAMPLE_BITS-1:0]   div_quo;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W-1:0]         div_num;
    logic signed [ACC_W-1:0]  prod_w;
    logic signed [ACC_W-1:0]  quo_ext;
    logic [SAMPLE_BITS-1:0]   sat_w;

    assign order_p1 = OT_W'(order_reg) + OT_W'(1);
    assign taps_w   = (order_p1 > OT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(order_p1);
    assign n_w      = taps_w - CNT_W'(1);
    assign fill_new = (fill_reg < taps_w) ? fill_reg + CNT_W'(1) : fill_reg;
    assign wp_new   = (CNT_W'(wp_reg) + CNT_W'(1) == taps_w) ? '0 : wp_reg + RING_AW'(1);
    assign rp_inc   = (CNT_W'(rp_reg) + CNT_W'(1) == taps_w) ? '0 : rp_reg + RING_AW'(1);

    assign cfg.ready = (state_reg == S_IDLE) || (state_reg == S_BUILD_INIT) ||
                       (state_reg == S_BUILD_RD) || (state_reg == S_BUILD_WR);
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign samples.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign in_acc    = samples.valid && samples.ready;

    assign drain_done = !rd_vld_reg && !prod_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        order_next = order_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        warm_next  = warm_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        k_next     = k_reg;
        br_next    = br_reg;
        bk_next    = bk_reg;
        hold_next  = hold_reg;
        ring_we    = 1'b0;
        wgt_we     = 1'b0;
        wgt_waddr  = bk_reg;
        wgt_wdata  = hold_reg + wgt_rd_reg;
        wgt_raddr  = k_reg;
        out_load   = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            S_BUILD_INIT:
            begin
                wgt_we    = 1'b1;
                wgt_waddr = '0;
                wgt_wdata = WEIGHT_W'(1);
                br_next   = RING_AW'(1);
                bk_next   = RING_AW'(1);
                hold_next = '0;
                state_next = (n_w == '0) ? S_IDLE : S_BUILD_RD;
            end
            S_BUILD_RD:
            begin
                wgt_raddr  = bk_reg - RING_AW'(1);
                state_next = S_BUILD_WR;
            end
            S_BUILD_WR:
            begin
                wgt_we    = 1'b1;
                hold_next = wgt_rd_reg;
                if (bk_reg == RING_AW'(1))
                begin
                    if (CNT_W'(br_reg) == n_w)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        br_next    = br_reg + RING_AW'(1);
                        bk_next    = br_reg + RING_AW'(1);
                        hold_next  = '0;
                        state_next = S_BUILD_RD;
                    end
                end
                else
                begin
                    bk_next    = bk_reg - RING_AW'(1);
                    state_next = S_BUILD_RD;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ring_we    = 1'b1;
                    wp_next    = wp_new;
                    fill_next  = fill_new;
                    warm_next  = (fill_new < taps_w);
                    cnt_next   = (fill_new < taps_w) ? fill_new : taps_w;
                    rp_next    = (fill_new < taps_w) ? '0 : wp_new;
                    k_next     = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                rp_next  = rp_inc;
                k_next   = k_reg + RING_AW'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    if (warm_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_vld_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BUILD_INIT;
            end
        endcase

        if (cfg_acc)
        begin
            order_next = cfg.order;
            wp_next    = '0;
            fill_next  = '0;
            state_next = S_BUILD_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_BUILD_INIT;
            order_reg    <= ORDER_W'(RESET_ORDER);
            wp_reg       <= '0;
            fill_reg     <= '0;
            warm_reg     <= 1'b0;
            cnt_reg      <= '0;
            rp_reg       <= '0;
            k_reg        <= '0;
            br_reg       <= '0;
            bk_reg       <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            warm_reg     <= warm_next;
            cnt_reg      <= cnt_next;
            rp_reg       <= rp_next;
            k_reg        <= k_next;
            br_reg       <= br_next;
            bk_reg       <= bk_next;
            rd_vld_reg   <= (state_reg == S_MAC);
            prod_vld_reg <= rd_vld_reg;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= samples.sample;
        end
        ring_rd_reg <= ring_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wgt_we)
        begin
            wgt_mem[wgt_waddr] <= wgt_wdata;
        end
        wgt_rd_reg <= wgt_mem[wgt_raddr];
    end

    assign prod_w  = $signed({1'b0, wgt_rd_reg}) * ring_rd_reg;
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_num = acc_mag + ACC_W'(wsum_reg >> 1);
    assign quo_ext = $signed({{(ACC_W - SAMPLE_BITS){1'b0}}, div_quo});

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        prod_reg <= prod_w;
        wq_reg   <= wgt_rd_reg;
        if (in_acc)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg  <= acc_reg + prod_reg;
            wsum_reg <= wsum_reg + wq_reg;
        end
        if ((state_reg == S_DRAIN) && drain_done)
        begin
            sign_reg <= acc_reg[ACC_W-1];
            res_reg  <= acc_reg >>> n_w;
        end
        else if ((state_reg == S_DIV) && div_done)
        begin
            res_reg <= sign_reg ? -quo_ext : quo_ext;
        end
        if (out_load)
        begin
            out_data_reg <= sat_w;
        end
    end

    always_comb
    begin
        if (res_reg > SAT_HI)
        begin
            sat_w = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (res_reg < SAT_LO)
        begin
            sat_w = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_w = res_reg[SAMPLE_BITS-1:0];
        end
    end

    bsf_div #(
        .NUM_W (ACC_W),
        .DEN_W (WEIGHT_W),
        .QUO_W (SAMPLE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (wsum_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign results.valid    = out_vld_reg;
    assign results.smoothed = out_data_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= taps_w)
        else $error("fill count beyond tap count");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(wp_reg) < taps_w)
        else $error("ring write pointer beyond tap count");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside division state");

    a_item_start: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> ((state_reg == S_MAC) && (k_reg == '0)))
        else $error("accepted item did not start at the oldest tap");
`endif

endmodule

`default_nettype wire
